### sv/sfvg_pkg.sv
// Package with the glyph tables, configuration codes and controller interface types.
package sfvg_pkg;

    localparam int CoordWidthDef    = 24;
    localparam int CoordFracBitsDef = 8;
    localparam int GlyphCount       = 92;
    localparam int RomDepth         = 411;
    localparam int MaxPoints        = 16;
    localparam int InDataWidth      = 56;
    localparam int CfgIdxWidth      = 2;
    localparam int CfgDataWidth     = 16;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_UNIT_SIZE = 2'd0,
        CFG_COS_ANGLE = 2'd1,
        CFG_SIN_ANGLE = 2'd2
    } t_cfg_idx;

    localparam logic [8:0] GLYPH_START [0:GlyphCount-1] = '{
        9'd1, 9'd7, 9'd17, 9'd21, 9'd26, 9'd31, 9'd36, 9'd41, 9'd45, 9'd49, 9'd55,
        9'd64, 9'd74, 9'd79, 9'd81,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
        9'd83, 9'd87, 9'd91, 9'd101, 9'd107, 9'd110, 9'd112, 9'd117, 9'd119,
        9'd128, 9'd134, 9'd143, 9'd159, 9'd163,
        9'd172, 9'd183, 9'd188, 9'd204, 9'd215, 9'd0, 9'd0, 9'd215, 9'd220,
        9'd0, 9'd0, 9'd220, 9'd229, 9'd243, 9'd251, 9'd258,
        9'd265, 9'd271, 9'd283, 9'd291, 9'd299, 9'd305, 9'd313, 9'd316, 9'd321,
        9'd325, 9'd334, 9'd341, 9'd353, 9'd363,
        9'd373, 9'd378, 9'd384, 9'd387, 9'd392, 9'd397, 9'd403, 9'd412
    };

    localparam logic [7:0] STROKE_ROM [0:RomDepth-1] = '{
        8'd47,8'd17,8'd11,8'd71,8'd77,8'd47,8'd47,8'd37,8'd15,8'd13,
        8'd31,8'd51,8'd73,8'd75,8'd57,8'd47,8'd47,8'd11,8'd71,8'd47,
        8'd47,8'd41,8'd0,8'd14,8'd74,8'd17,8'd71,8'd0,8'd11,8'd77,
        8'd47,8'd14,8'd41,8'd74,8'd47,8'd47,8'd14,8'd74,8'd47,8'd41,
        8'd11,8'd77,8'd17,8'd71,8'd17,8'd77,8'd11,8'd71,8'd17,8'd44,
        8'd77,8'd0,8'd44,8'd41,8'd17,8'd71,8'd0,8'd11,8'd77,8'd17,
        8'd11,8'd71,8'd77,8'd47,8'd41,8'd0,8'd14,8'd74,8'd77,8'd17,
        8'd11,8'd71,8'd74,8'd77,8'd11,8'd71,8'd17,8'd77,8'd47,8'd41,
        8'd0,8'd0,8'd27,8'd16,8'd12,8'd21,8'd47,8'd56,8'd52,8'd41,
        8'd25,8'd43,8'd0,8'd33,8'd35,8'd0,8'd45,8'd23,8'd0,8'd24,
        8'd44,8'd24,8'd44,8'd0,8'd35,8'd33,8'd32,8'd41,8'd30,8'd24,
        8'd44,8'd31,8'd41,8'd42,8'd32,8'd31,8'd11,8'd57,8'd21,8'd12,
        8'd16,8'd27,8'd47,8'd56,8'd52,8'd41,8'd21,8'd26,8'd37,8'd31,
        8'd0,8'd21,8'd41,8'd15,8'd16,8'd27,8'd47,8'd56,8'd55,8'd12,
        8'd11,8'd51,8'd15,8'd16,8'd27,8'd47,8'd56,8'd55,8'd44,8'd53,
        8'd52,8'd41,8'd21,8'd12,8'd13,8'd0,8'd34,8'd44,8'd41,8'd47,
        8'd14,8'd54,8'd57,8'd17,8'd14,8'd44,8'd53,8'd52,8'd41,8'd21,
        8'd12,8'd56,8'd47,8'd27,8'd16,8'd12,8'd21,8'd41,8'd52,8'd53,
        8'd44,8'd14,8'd16,8'd17,8'd57,8'd56,8'd31,8'd24,8'd15,8'd16,
        8'd27,8'd47,8'd56,8'd55,8'd44,8'd53,8'd52,8'd41,8'd21,8'd12,
        8'd13,8'd24,8'd44,8'd54,8'd24,8'd15,8'd16,8'd27,8'd47,8'd56,
        8'd52,8'd41,8'd21,8'd12,8'd35,8'd55,8'd0,8'd33,8'd53,8'd11,
        8'd16,8'd27,8'd47,8'd56,8'd51,8'd0,8'd14,8'd54,8'd17,8'd11,
        8'd41,8'd52,8'd53,8'd44,8'd44,8'd55,8'd56,8'd47,8'd17,8'd0,
        8'd14,8'd44,8'd56,8'd47,8'd27,8'd16,8'd12,8'd21,8'd41,8'd52,
        8'd52,8'd56,8'd47,8'd17,8'd11,8'd41,8'd52,8'd57,8'd17,8'd11,
        8'd51,8'd0,8'd44,8'd14,8'd57,8'd17,8'd11,8'd0,8'd44,8'd14,
        8'd54,8'd52,8'd41,8'd21,8'd12,8'd16,8'd27,8'd47,8'd56,8'd0,
        8'd44,8'd64,8'd11,8'd17,8'd0,8'd14,8'd54,8'd0,8'd57,8'd51,
        8'd17,8'd57,8'd0,8'd37,8'd31,8'd0,8'd11,8'd51,8'd57,8'd52,
        8'd41,8'd21,8'd12,8'd13,8'd17,8'd11,8'd0,8'd14,8'd51,8'd0,
        8'd14,8'd57,8'd17,8'd11,8'd51,8'd11,8'd17,8'd35,8'd57,8'd51,
        8'd11,8'd17,8'd51,8'd57,8'd21,8'd12,8'd16,8'd27,8'd47,8'd56,
        8'd52,8'd41,8'd21,8'd11,8'd17,8'd47,8'd56,8'd55,8'd44,8'd14,
        8'd21,8'd12,8'd16,8'd27,8'd47,8'd56,8'd52,8'd41,8'd21,8'd0,
        8'd42,8'd51,8'd11,8'd17,8'd47,8'd56,8'd55,8'd44,8'd14,8'd0,
        8'd44,8'd51,8'd56,8'd47,8'd27,8'd16,8'd15,8'd53,8'd52,8'd41,
        8'd21,8'd12,8'd17,8'd57,8'd0,8'd37,8'd31,8'd17,8'd12,8'd21,
        8'd41,8'd52,8'd57,8'd17,8'd31,8'd57,8'd17,8'd11,8'd34,8'd51,
        8'd57,8'd17,8'd51,8'd0,8'd11,8'd57,8'd17,8'd34,8'd57,8'd0,
        8'd34,8'd31,8'd17,8'd57,8'd56,8'd12,8'd11,8'd51,8'd0,8'd24,
        8'd44
    };

    typedef struct packed {
        logic load_origin;
        logic start_char;
        logic fetch;
        logic lift;
        logic decode;
        logic mult;
        logic sum;
        logic place;
        logic push;
        logic push_last;
        logic adv_mul;
        logic adv_org;
    } t_cmd;

    typedef struct packed {
        logic past_end;
        logic count_full;
        logic sb_zero;
        logic out_full;
        logic pend_valid;
    } t_stat;

endpackage

### sv/sfvg_ctrl.sv
// Controller state machine that sequences lookup, stroke walk, output and origin advance.
module sfvg_ctrl
    import sfvg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_draw,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_FETCH   = 11'b000_0000_0010,
        ST_DECODE  = 11'b000_0000_0100,
        ST_MULT    = 11'b000_0000_1000,
        ST_SUM     = 11'b000_0001_0000,
        ST_PLACE   = 11'b000_0010_0000,
        ST_FINISH  = 11'b000_0100_0000,
        ST_ADV_MUL = 11'b000_1000_0000,
        ST_ADV_SUM = 11'b001_0000_0000,
        ST_ADV_ORG = 11'b010_0000_0000,
        ST_SPARE   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_draw) begin
                        o_cmd.start_char = 1'b1;
                        n_state = ST_FETCH;
                    end else begin
                        o_cmd.load_origin = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                if (i_stat.past_end || i_stat.count_full) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.sb_zero) begin
                    o_cmd.lift = 1'b1;
                    n_state = ST_FETCH;
                end else begin
                    o_cmd.decode = 1'b1;
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ST_PLACE;
            end
            ST_PLACE: begin
                if (!i_stat.pend_valid || !i_stat.out_full) begin
                    o_cmd.place = 1'b1;
                    o_cmd.push  = i_stat.pend_valid;
                    n_state = ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (!i_stat.out_full) begin
                    o_cmd.push_last = 1'b1;
                    n_state = ST_ADV_MUL;
                end
            end
            ST_ADV_MUL: begin
                o_cmd.adv_mul = 1'b1;
                n_state = ST_ADV_SUM;
            end
            ST_ADV_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ST_ADV_ORG;
            end
            ST_ADV_ORG: begin
                o_cmd.adv_org = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/sfvg_dp.sv
// Datapath with configuration, origin, stroke ROM, rotation arithmetic and output register.
module sfvg_dp
    import sfvg_pkg::*;
#(
    parameter int COORD_WIDTH     = CoordWidthDef,
    parameter int COORD_FRAC_BITS = CoordFracBitsDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [CfgDataWidth-1:0] i_cfg_data,
    input  logic [23:0]             i_origin_x,
    input  logic [23:0]             i_origin_y,
    input  logic [7:0]              i_char_code,
    input  logic                    i_string_end,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [COORD_WIDTH-1:0]  o_point_x,
    output logic [COORD_WIDTH-1:0]  o_point_y,
    output logic                    o_pen_down,
    output logic                    o_point_valid,
    output logic                    o_last_of_item,
    output logic                    o_string_done
);

    localparam int W     = 41;
    localparam int Shift = 22 - COORD_FRAC_BITS;
    localparam logic signed [W-1:0] Half = W'(1) <<< (Shift - 1);
    localparam logic signed [W-1:0] MaxV = (W'(1) <<< (COORD_WIDTH - 1)) - W'(1);
    localparam logic signed [W-1:0] MinV = -MaxV - W'(1);

    function automatic logic [COORD_WIDTH-1:0] f_sat(input logic signed [W-1:0] v);
        logic [COORD_WIDTH-1:0] res;
        if (v > MaxV) begin
            res = MaxV[COORD_WIDTH-1:0];
        end else if (v < MinV) begin
            res = MinV[COORD_WIDTH-1:0];
        end else begin
            res = v[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    function automatic logic [8:0] f_glyph(input logic [7:0] c);
        logic [8:0] res;
        if (c < 8'(GlyphCount)) begin
            res = GLYPH_START[c[6:0]];
        end else begin
            res = 9'd0;
        end
        return res;
    endfunction

    logic        [15:0]            r_unit;
    logic signed [15:0]            r_cos;
    logic signed [15:0]            r_sin;
    logic        [COORD_WIDTH-1:0] r_org_x;
    logic        [COORD_WIDTH-1:0] r_org_y;
    logic        [8:0]             r_addr;
    logic        [8:0]             r_next;
    logic                          r_glyph;
    logic                          r_send;
    logic        [7:0]             r_sb;
    logic                          r_lifted;
    logic        [4:0]             r_count;
    logic signed [22:0]            r_xx;
    logic signed [22:0]            r_yy;
    logic signed [38:0]            r_p1;
    logic signed [38:0]            r_p2;
    logic signed [38:0]            r_p3;
    logic signed [38:0]            r_p4;
    logic signed [W-1:0]           r_rx;
    logic signed [W-1:0]           r_ry;
    logic                          r_pend_v;
    logic        [COORD_WIDTH-1:0] r_pend_x;
    logic        [COORD_WIDTH-1:0] r_pend_y;
    logic                          r_pend_pen;
    logic                          r_out_v;

    logic        [7:0]  w_fold;
    logic        [8:0]  w_first;
    logic        [15:0] w_div;
    logic        [4:0]  w_tens;
    logic        [7:0]  w_units;
    logic signed [22:0] w_gx;
    logic signed [22:0] w_gy;
    logic signed [22:0] w_u;
    logic signed [19:0] w_u7;
    logic signed [W-1:0] w_vx;
    logic signed [W-1:0] w_vy;
    logic signed [W-1:0] w_ox;
    logic signed [W-1:0] w_oy;

    assign w_fold  = (i_char_code >= 8'd97 && i_char_code <= 8'd122) ?
                     i_char_code - 8'd32 : i_char_code;
    assign w_first = f_glyph(w_fold);
    assign w_div   = {8'd0, r_sb} * 16'd205;
    assign w_tens  = w_div[15:11];
    assign w_units = r_sb - {3'd0, w_tens} * 8'd10;
    assign w_gx    = 23'($signed({1'b0, w_tens})) - 23'sd1;
    assign w_gy    = 23'sd9 - 23'($signed({1'b0, w_units[3:0]}));
    assign w_u     = 23'($signed({1'b0, r_unit}));
    assign w_u7    = 20'($signed({1'b0, r_unit, 3'd0})) - 20'($signed({1'b0, r_unit}));
    assign w_vx    = (W'(r_p1) - W'(r_p2) + Half) >>> Shift;
    assign w_vy    = (W'(r_p3) + W'(r_p4) + Half) >>> Shift;
    assign w_ox    = W'($signed(r_org_x)) + r_rx;
    assign w_oy    = W'($signed(r_org_y)) + r_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= 16'd293;
            r_cos   <= 16'sd16384;
            r_sin   <= 16'sd0;
            r_org_x <= '0;
            r_org_y <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UNIT_SIZE: r_unit <= i_cfg_data;
                    CFG_COS_ANGLE: r_cos  <= $signed(i_cfg_data);
                    CFG_SIN_ANGLE: r_sin  <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.load_origin) begin
                r_org_x <= f_sat(W'($signed(i_origin_x)));
                r_org_y <= f_sat(W'($signed(i_origin_y)));
            end else if (i_cmd.adv_org) begin
                r_org_x <= f_sat(w_ox);
                r_org_y <= f_sat(w_oy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_count  <= '0;
            r_lifted <= 1'b1;
        end else begin
            if (i_cmd.start_char) begin
                r_pend_v <= 1'b0;
                r_count  <= '0;
                r_lifted <= 1'b1;
            end
            if (i_cmd.lift) begin
                r_lifted <= 1'b1;
            end
            if (i_cmd.place) begin
                r_pend_v <= 1'b1;
                r_count  <= r_count + 5'd1;
                r_lifted <= 1'b0;
            end
            if (i_cmd.push || i_cmd.push_last) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_char) begin
            r_addr  <= w_first;
            r_next  <= f_glyph(w_fold + 8'd1);
            r_glyph <= (w_fold <= 8'd90) && (w_first != 9'd0);
            r_send  <= i_string_end;
        end
        if (i_cmd.fetch) begin
            r_sb   <= STROKE_ROM[r_addr - 9'd1];
            r_addr <= r_addr + 9'd1;
        end
        if (i_cmd.decode) begin
            r_xx <= w_gx * w_u;
            r_yy <= w_gy * w_u;
        end
        if (i_cmd.mult) begin
            r_p1 <= 39'(r_xx) * 39'(r_cos);
            r_p2 <= 39'(r_yy) * 39'(r_sin);
            r_p3 <= 39'(r_xx) * 39'(r_sin);
            r_p4 <= 39'(r_yy) * 39'(r_cos);
        end else if (i_cmd.adv_mul) begin
            r_p1 <= 39'(w_u7) * 39'(r_cos);
            r_p2 <= '0;
            r_p3 <= 39'(w_u7) * 39'(r_sin);
            r_p4 <= '0;
        end
        if (i_cmd.sum) begin
            r_rx <= w_vx;
            r_ry <= w_vy;
        end
        if (i_cmd.place) begin
            r_pend_x   <= f_sat(w_ox);
            r_pend_y   <= f_sat(w_oy);
            r_pend_pen <= !r_lifted;
        end
        if (i_cmd.push) begin
            o_point_x      <= r_pend_x;
            o_point_y      <= r_pend_y;
            o_pen_down     <= r_pend_pen;
            o_point_valid  <= 1'b1;
            o_last_of_item <= 1'b0;
            o_string_done  <= 1'b0;
        end else if (i_cmd.push_last) begin
            o_point_x      <= r_pend_v ? r_pend_x : '0;
            o_point_y      <= r_pend_v ? r_pend_y : '0;
            o_pen_down     <= r_pend_v & r_pend_pen;
            o_point_valid  <= r_pend_v;
            o_last_of_item <= 1'b1;
            o_string_done  <= r_send;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_stat.past_end   = !r_glyph || (r_addr >= r_next);
    assign o_stat.count_full = (r_count == 5'(MaxPoints));
    assign o_stat.sb_zero    = (r_sb == 8'd0);
    assign o_stat.out_full   = r_out_v && !i_out_ready;
    assign o_stat.pend_valid = r_pend_v;

endmodule

### sv/stroke_font_vector_generator_top.sv
// Top level of the stroke font vector generator: controller plus datapath.
//
//  Channel    Direction  Moves
//  s_axis     in         one request: set origin (tuser 0) or draw one character (tuser 1)
//  m_axis     out        one to sixteen beats per draw request (zero to sixteen valid points), tlast on the final one
//  cfg        in         register writes: unit size, cosine, sine
//
// A character looks up its glyph, then walks it point by point through fetch, decode,
// multiply, sum and place (a zero stroke byte lifts the pen), then sends the final point
// and advances the origin on the single shared multiply and round path; an origin load never leaves idle.
// Reset is synchronous and restores the registers and a zero origin.
// A stalled output holds the walk only when a new point must be handed over.
module stroke_font_vector_generator_top
    import sfvg_pkg::*;
#(
    parameter int COORD_WIDTH     = CoordWidthDef,
    parameter int COORD_FRAC_BITS = CoordFracBitsDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // origin_x, origin_y, char_code
    input  logic [InDataWidth-1:0]  i_s_axis_tdata,
    // operation
    input  logic                    i_s_axis_tuser,
    input  logic                    i_s_axis_tlast,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // point_x, point_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // pen_down, point_valid, string_done
    output logic [2:0]              o_m_axis_tuser,
    output logic                    o_m_axis_tlast,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [CfgDataWidth-1:0] i_cfg_data
);

    localparam int OutW = ((2*COORD_WIDTH+7)/8)*8;

    t_cmd                   w_cmd;
    t_stat                  w_stat;
    logic [COORD_WIDTH-1:0] w_px;
    logic [COORD_WIDTH-1:0] w_py;
    logic                   w_pen;
    logic                   w_pv;
    logic                   w_done;

    sfvg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_draw  (i_s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    sfvg_dp #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_origin_x     (i_s_axis_tdata[23:0]),
        .i_origin_y     (i_s_axis_tdata[47:24]),
        .i_char_code    (i_s_axis_tdata[55:48]),
        .i_string_end   (i_s_axis_tlast),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_point_x      (w_px),
        .o_point_y      (w_py),
        .o_pen_down     (w_pen),
        .o_point_valid  (w_pv),
        .o_last_of_item (o_m_axis_tlast),
        .o_string_done  (w_done)
    );

    assign o_m_axis_tdata = OutW'({w_py, w_px});
    assign o_m_axis_tuser = {w_done, w_pv, w_pen};

endmodule
